/* design/vpa_pkg.sv */
`default_nettype none
package vpa_pkg;
   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_APPEND  = 2'd1;
   localparam logic [1:0] CMD_ALLOC   = 2'd2;
   localparam logic [1:0] CMD_RELEASE = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NOOWNER = 2'd3;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_NEXT  = 2'd1;
   localparam logic [1:0] POL_BEST  = 2'd2;
   localparam logic [1:0] POL_WORST = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] owner_id;
      logic [31:0] base_address;
      logic [31:0] request_size;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] block_addr;
      logic [31:0] block_size;
   } rsp_type;
endpackage
`default_nettype wire

/* design/vpa_ram.sv */
`default_nettype none
module vpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* design/variable_partition_allocator.sv */
// Channel | Direction | Handshake              | Beat
// req     | in        | start && !busy         | req_type (cmd, owner, base, size)
// rsp     | out       | rsp_strobe, one cycle  | rsp_type (status, addr, size)
// csr     | in        | csr_valid && csr_ready | fit_policy, 2 bits
//
// One command at a time. Each scan reads one entry per cycle from the table RAM
// (the RAM read is registered). Next fit first reduces its start index modulo
// the count by repeated subtraction. A split shifts entries up and a release may
// shift down twice, one entry at a time (read then write). Reset is synchronous;
// the table needs no clearing since only entries below the count are read. The
// receiver cannot stall: rsp_strobe pulses once.
`default_nettype none
module variable_partition_allocator
   import vpa_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int OWNER_BITS  = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [1:0] csr_data
);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = IW + 1;
   localparam int EW = 32 + 32 + OWNER_BITS + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_PICK = 4'd2, S_SHUP = 4'd3,
      S_SHUPW = 4'd4, S_SPLIT = 4'd5, S_MERGE_RD = 4'd6, S_MERGE_CK = 4'd7,
      S_SHDN = 4'd8, S_SHDNW = 4'd9, S_DONE = 4'd10, S_PICKRD = 4'd11, S_MOD = 4'd12;

   typedef struct packed {
      logic [31:0]           base;
      logic [31:0]           size;
      logic [OWNER_BITS-1:0] owner;
      logic                  taken;
   } entry_type;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  policy_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] next_ff, next_in;
   req_type     req_ff;
   logic [CW-1:0] scan_ff, scan_in;     // entries visited
   logic [IW-1:0] rd_ff, rd_in;         // index of entry being read
   logic [IW-1:0] pos_ff, pos_in;       // index of data now on rd_data
   logic          rdv_ff, rdv_in;
   logic          found_ff, found_in;
   logic [IW-1:0] pick_ff, pick_in;
   entry_type     pe_ff, pe_in;         // picked entry
   logic [IW-1:0] k_ff, k_in;           // shift cursor
   logic          phase_ff, phase_in;   // merge step: 0 left, 1 right
   rsp_type       rsp_ff, rsp_in;
   logic          strobe_ff, strobe_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   entry_type     wr_e, rd_e;
   logic [EW-1:0] rd_raw;
   logic [OWNER_BITS-1:0] own;
   logic          hit;

   vpa_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_e),
      .rd_addr(rd_addr), .rd_data(rd_raw));
   assign rd_e = entry_type'(rd_raw);
   assign own  = OWNER_BITS'(req_ff.owner_id);

   assign busy       = state_ff != S_IDLE;
   assign csr_ready  = state_ff == S_IDLE && !start;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // qualify the scanned entry
   always_comb begin
      hit = 1'b0;
      if (req_ff.cmd == CMD_RELEASE) hit = rd_e.taken && rd_e.owner == own;
      else if (!rd_e.taken && rd_e.size >= req_ff.request_size) begin
         case (policy_ff)
            POL_BEST:  hit = !found_ff || rd_e.size < pe_ff.size;
            POL_WORST: hit = !found_ff || rd_e.size > pe_ff.size;
            default:   hit = !found_ff;
         endcase
      end
   end

   function automatic logic [IW-1:0] wrapi(input logic [CW-1:0] v, input logic [CW-1:0] n);
      logic [CW-1:0] r;
      r = (v >= n) ? v - n : v;
      return r[IW-1:0];
   endfunction

   always_comb begin
      state_in = state_ff; count_in = count_ff; next_in = next_ff;
      scan_in = scan_ff; rd_in = rd_ff; pos_in = pos_ff; rdv_in = 1'b0;
      found_in = found_ff; pick_in = pick_ff; pe_in = pe_ff; k_in = k_ff;
      phase_in = phase_ff; rsp_in = rsp_ff; strobe_in = 1'b0;
      wr_en = 1'b0; wr_addr = '0; wr_e = '0; rd_addr = rd_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            rsp_in = '0;
            found_in = 1'b0;
            scan_in = '0;
            phase_in = 1'b0;
            case (req_data.cmd)
               CMD_CLEAR: begin
                  count_in = '0; next_in = '0; strobe_in = 1'b1;
               end
               CMD_APPEND: begin
                  strobe_in = 1'b1;
                  if (count_ff >= DEPTH_C) rsp_in.status = ST_FULL;
                  else begin
                     wr_en = 1'b1; wr_addr = count_ff[IW-1:0];
                     wr_e = '{base: req_data.base_address, size: req_data.request_size,
                              owner: '0, taken: 1'b0};
                     count_in = count_ff + 1'b1;
                     rsp_in.block_addr = req_data.base_address;
                     rsp_in.block_size = req_data.request_size;
                  end
               end
               default: begin
                  if (count_ff == '0) begin
                     strobe_in = 1'b1;
                     rsp_in.status = (req_data.cmd == CMD_ALLOC) ? ST_NOFIT : ST_NOOWNER;
                  end else begin
                     // next fit starts at next_start mod count: reduce it first
                     rd_in = '0;
                     state_in = S_SCAN;
                     if (req_data.cmd == CMD_ALLOC && policy_ff == POL_NEXT) begin
                        rd_in = next_ff; state_in = S_MOD;
                     end
                  end
               end
            endcase
         end
         S_MOD: begin
            // subtract the count until the start index lies inside the table
            if (CW'(rd_ff) >= count_ff) rd_in = wrapi(CW'(rd_ff), count_ff);
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            // issue read of rd_ff, check entry from previous read
            if (rdv_ff && hit) begin
               found_in = 1'b1; pick_in = pos_ff; pe_in = rd_e;
            end
            if (rdv_ff && hit && (policy_ff == POL_FIRST || policy_ff == POL_NEXT ||
                req_ff.cmd == CMD_RELEASE)) begin
               state_in = S_PICK;
            end else if (scan_ff < count_ff) begin
               pos_in = rd_ff; rdv_in = 1'b1; scan_in = scan_ff + 1'b1;
               rd_in = wrapi(CW'(rd_ff) + 1'b1, count_ff);
            end else if (!rdv_ff) state_in = S_PICK;
         end
         S_PICK: begin
            if (!found_ff) begin
               strobe_in = 1'b1; state_in = S_IDLE;
               rsp_in.status = (req_ff.cmd == CMD_ALLOC) ? ST_NOFIT : ST_NOOWNER;
            end else if (req_ff.cmd == CMD_RELEASE) begin
               rsp_in.block_addr = pe_ff.base; rsp_in.block_size = pe_ff.size;
               pe_in.taken = 1'b0; pe_in.owner = '0;
               wr_en = 1'b1; wr_addr = pick_ff;
               wr_e = '{base: pe_ff.base, size: pe_ff.size, owner: '0, taken: 1'b0};
               phase_in = 1'b0;
               if (pick_ff != '0) begin
                  rd_addr = pick_ff - 1'b1; state_in = S_MERGE_RD;
               end else begin
                  phase_in = 1'b1; state_in = S_PICKRD;
               end
            end else if (pe_ff.size > req_ff.request_size) begin
               if (count_ff >= DEPTH_C) begin
                  rsp_in.status = ST_FULL; strobe_in = 1'b1; state_in = S_IDLE;
               end else begin
                  k_in = count_ff[IW-1:0]; state_in = S_SHUP;
               end
            end else state_in = S_SPLIT;
         end
         S_SHUP: begin
            // move entry k-1 to k for k from count down to pick+2
            if (CW'(k_ff) > CW'(pick_ff) + 1'b1) begin
               rd_addr = k_ff - 1'b1; state_in = S_SHUPW;
            end else state_in = S_SPLIT;
         end
         S_SHUPW: begin
            wr_en = 1'b1; wr_addr = k_ff; wr_e = rd_e;
            k_in = k_ff - 1'b1; state_in = S_SHUP;
         end
         S_SPLIT: begin
            if (pe_ff.size > req_ff.request_size && !phase_ff) begin
               wr_en = 1'b1; wr_addr = pick_ff + 1'b1;
               wr_e = '{base: pe_ff.base + req_ff.request_size,
                        size: pe_ff.size - req_ff.request_size, owner: '0, taken: 1'b0};
               count_in = count_ff + 1'b1; phase_in = 1'b1;
            end else begin
               wr_en = 1'b1; wr_addr = pick_ff;
               wr_e = '{base: pe_ff.base, size: req_ff.request_size, owner: own,
                        taken: 1'b1};
               rsp_in.block_addr = pe_ff.base; rsp_in.block_size = req_ff.request_size;
               if (policy_ff == POL_NEXT)
                  next_in = (CW'(pick_ff) + 1'b1 >= DEPTH_C) ? '0 : pick_ff + 1'b1;
               phase_in = 1'b0; strobe_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_PICKRD: begin
            // read right neighbor of pick
            rd_addr = pick_ff + 1'b1; state_in = S_MERGE_CK;
            if (CW'(pick_ff) + 1'b1 >= count_ff) begin
               strobe_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_MERGE_RD: begin
            // hold the left neighbor address so its data is on rd_data next cycle
            rd_addr = pick_ff - 1'b1; state_in = S_MERGE_CK;
         end
         S_MERGE_CK: begin
            if (!phase_ff) begin
               if (!rd_e.taken) begin
                  wr_en = 1'b1; wr_addr = pick_ff - 1'b1;
                  wr_e = rd_e; wr_e.size = rd_e.size + pe_ff.size;
                  pe_in = wr_e; pick_in = pick_ff - 1'b1;
                  k_in = pick_ff; state_in = S_SHDN;
               end else begin
                  phase_in = 1'b1; state_in = S_PICKRD;
               end
            end else begin
               if (!rd_e.taken) begin
                  wr_en = 1'b1; wr_addr = pick_ff;
                  wr_e = pe_ff; wr_e.size = pe_ff.size + rd_e.size;
                  pe_in = wr_e; k_in = pick_ff + 1'b1; state_in = S_SHDN;
               end else begin
                  strobe_in = 1'b1; state_in = S_IDLE;
               end
            end
         end
         S_SHDN: begin
            // copy k+1 to k while k+1 < count, then drop count
            if (CW'(k_ff) + 1'b1 < count_ff) begin
               rd_addr = k_ff + 1'b1; state_in = S_SHDNW;
            end else begin
               count_in = count_ff - 1'b1;
               if (!phase_ff) begin
                  phase_in = 1'b1; state_in = S_PICKRD;
               end else begin
                  strobe_in = 1'b1; state_in = S_IDLE;
               end
            end
         end
         S_SHDNW: begin
            wr_en = 1'b1; wr_addr = k_ff; wr_e = rd_e;
            k_in = k_ff + 1'b1; state_in = S_SHDN;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; policy_ff <= POL_FIRST; count_ff <= '0; next_ff <= '0;
         strobe_ff <= 1'b0; rdv_ff <= 1'b0; phase_ff <= 1'b0; found_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; next_ff <= next_in;
         strobe_ff <= strobe_in; rdv_ff <= rdv_in; phase_ff <= phase_in;
         found_ff <= found_in;
         if (csr_valid && csr_ready) policy_ff <= csr_data;
      end
      if (state_ff == S_IDLE && start) req_ff <= req_data;
      scan_ff <= scan_in; rd_ff <= rd_in; pos_ff <= pos_in; pick_ff <= pick_in;
      pe_ff <= pe_in; k_ff <= k_in; rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

/* design/vpa_checker.sv */
`default_nettype none
module vpa_checker
   import vpa_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data,
   input wire logic    csr_valid,
   input wire logic    csr_ready
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && $past(!reset) |=> busy || rsp_strobe)
      else $error("accepted beat left no trace");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("strobe while busy");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy) else $error("csr ready while busy");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_OK |-> rsp_data.block_addr == 0 &&
      rsp_data.block_size == 0) else $error("failure carries data");
endmodule
bind variable_partition_allocator vpa_checker u_vpa_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_strobe(rsp_strobe),
   .rsp_data(rsp_data), .csr_valid(csr_valid), .csr_ready(csr_ready));
`default_nettype wire

/* bench/variable_partition_allocator_tb.sv */
`default_nettype none
module variable_partition_allocator_tb
   import vpa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 64;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_WAIT = 6 * DEPTH;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0] csr_data;

   variable_partition_allocator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow copy of the region table and allocator registers.
   logic [31:0] shadow_base  [DEPTH];
   logic [31:0] shadow_size  [DEPTH];
   logic [15:0] shadow_owner [DEPTH];
   logic        shadow_taken [DEPTH];
   int          shadow_count;
   int          shadow_next;
   logic [1:0]  shadow_policy;

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   int      error_count;
   int      idle_cycles;
   int      gap_left;
   bit      stim_done;

   // Pick a free region for the request under the current policy; -1 if none.
   function automatic int pick_region(logic [31:0] want);
      int pick;
      int j;
      pick = -1;
      if (shadow_count == 0) return -1;
      if (shadow_policy == POL_NEXT) begin
         for (int k = 0; k < shadow_count; k++) begin
            j = (shadow_next % shadow_count + k) % shadow_count;
            if (!shadow_taken[j] && shadow_size[j] >= want) return j;
         end
         return -1;
      end
      for (int k = 0; k < shadow_count; k++) begin
         if (shadow_taken[k] || shadow_size[k] < want) continue;
         if (shadow_policy == POL_FIRST) return k;
         if (pick < 0 || (shadow_policy == POL_BEST && shadow_size[k] < shadow_size[pick]) ||
             (shadow_policy == POL_WORST && shadow_size[k] > shadow_size[pick]))
            pick = k;
      end
      return pick;
   endfunction

   function automatic void drop_entry(int idx);
      for (int k = idx; k + 1 < shadow_count; k++) begin
         shadow_base[k]  = shadow_base[k+1];
         shadow_size[k]  = shadow_size[k+1];
         shadow_owner[k] = shadow_owner[k+1];
         shadow_taken[k] = shadow_taken[k+1];
      end
      shadow_count--;
   endfunction

   // Advance the shadow table by one command and return the expected response.
   function automatic rsp_type apply_command(req_type c);
      rsp_type r;
      int i;
      bit found;
      r = '0;
      r.status = ST_OK;
      case (c.cmd)
         CMD_CLEAR: begin
            shadow_count = 0;
            shadow_next  = 0;
         end
         CMD_APPEND: begin
            if (shadow_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_base[shadow_count]  = c.base_address;
               shadow_size[shadow_count]  = c.request_size;
               shadow_owner[shadow_count] = '0;
               shadow_taken[shadow_count] = 1'b0;
               shadow_count++;
               r.block_addr = c.base_address;
               r.block_size = c.request_size;
            end
         end
         CMD_ALLOC: begin
            i = pick_region(c.request_size);
            if (i < 0) begin
               r.status = ST_NOFIT;
            end else begin
               if (shadow_size[i] > c.request_size) begin
                  if (shadow_count >= DEPTH) begin
                     r.status = ST_FULL;
                  end else begin
                     for (int k = shadow_count; k > i + 1; k--) begin
                        shadow_base[k]  = shadow_base[k-1];
                        shadow_size[k]  = shadow_size[k-1];
                        shadow_owner[k] = shadow_owner[k-1];
                        shadow_taken[k] = shadow_taken[k-1];
                     end
                     shadow_base[i+1]  = shadow_base[i] + c.request_size;
                     shadow_size[i+1]  = shadow_size[i] - c.request_size;
                     shadow_owner[i+1] = '0;
                     shadow_taken[i+1] = 1'b0;
                     shadow_size[i]    = c.request_size;
                     shadow_count++;
                  end
               end
               if (r.status == ST_OK) begin
                  shadow_taken[i] = 1'b1;
                  shadow_owner[i] = c.owner_id;
                  r.block_addr    = shadow_base[i];
                  r.block_size    = c.request_size;
                  if (shadow_policy == POL_NEXT) shadow_next = (i + 1 >= DEPTH) ? 0 : i + 1;
               end
            end
         end
         default: begin
            found = 1'b0;
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_taken[i] && shadow_owner[i] == c.owner_id) begin
                  found = 1'b1;
                  break;
               end
            end
            if (!found) begin
               r.status = ST_NOOWNER;
            end else begin
               r.block_addr    = shadow_base[i];
               r.block_size    = shadow_size[i];
               shadow_taken[i] = 1'b0;
               shadow_owner[i] = '0;
               // Merge with a free left neighbor, then a free right neighbor.
               if (i > 0 && !shadow_taken[i-1]) begin
                  shadow_size[i-1] += shadow_size[i];
                  drop_entry(i);
                  i--;
               end
               if (i + 1 < shadow_count && !shadow_taken[i+1]) begin
                  shadow_size[i] += shadow_size[i+1];
                  drop_entry(i + 1);
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic req_type make_cmd(logic [1:0] op, logic [15:0] who,
                                        logic [31:0] base, logic [31:0] len);
      req_type c;
      c.cmd          = op;
      c.owner_id     = who;
      c.base_address = base;
      c.request_size = len;
      return c;
   endfunction

   // Mostly short gaps, a few long ones, often none.
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Owners come from a small pool so releases find their targets; some are wild.
   function automatic logic [15:0] draw_owner();
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 7)) ^ {16{$urandom_range(0, 3) == 0}};
   endfunction

   function automatic logic [31:0] draw_size();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'($urandom);
         2:       return 32'hFFFF_FFFF;
         default: return 32'($urandom_range(1, 64));
      endcase
   endfunction

   // Driver: at an accepting edge, take the next beat from the queue or pause for a random gap.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else if (start && !busy) begin
         expected_rsps.push_back(apply_command(req_data));
         if (pending_cmds.size() > 0 && draw_gap() == 0) begin
            req_data <= pending_cmds.pop_front();
         end else begin
            start    <= 1'b0;
            gap_left <= draw_gap();
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_cmds.size() > 0) begin
            start    <= 1'b1;
            req_data <= pending_cmds.pop_front();
         end
      end
   end

   // Monitor: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $error("response with nothing expected: status %0d", rsp_data.status);
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status expected %0d got %0d", exp_rsp.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.block_addr !== exp_rsp.block_addr) begin
               $error("block_addr expected %h got %h", exp_rsp.block_addr,
                      rsp_data.block_addr);
               error_count++;
            end
            if (rsp_data.block_size !== exp_rsp.block_size) begin
               $error("block_size expected %h got %h", exp_rsp.block_size,
                      rsp_data.block_size);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with no beat in either direction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (!stim_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("variable_partition_allocator_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_policy(logic [1:0] pol);
      csr_valid <= 1'b1;
      csr_data  <= pol;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_policy = pol;
      csr_valid <= 1'b0;
   endtask

   // Directed beats: extremes, every command, the special cases.
   task automatic load_directed();
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 16'h0001, 32'h0, 32'd1));        // empty table on the first pass
      pending_cmds.push_back(make_cmd(CMD_RELEASE, 16'hFFFF, 32'h0, 32'h0));      // unknown owner
      pending_cmds.push_back(make_cmd(CMD_APPEND, 16'hFFFF, 32'hFFFF_FFF0, 32'd100));
      pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h0, 32'h0000_1000, 32'd40));
      pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h0, 32'h0000_2000, 32'd40));
      pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h0, 32'h0000_3000, 32'hFFFF_FFFF));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 16'hFFFF, 32'h0, 32'd30));       // split wraps
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 16'h0000, 32'h0, 32'd40));       // exact fit
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 16'h0002, 32'h0, 32'd0));        // zero size
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 16'h0003, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 16'h0004, 32'h0, 32'hFFFF_FFFF)); // no fit
      pending_cmds.push_back(make_cmd(CMD_RELEASE, 16'h0000, 32'h0, 32'h0));
      pending_cmds.push_back(make_cmd(CMD_RELEASE, 16'hFFFF, 32'h0, 32'h0));
      pending_cmds.push_back(make_cmd(CMD_RELEASE, 16'h0002, 32'h0, 32'h0));
      pending_cmds.push_back(make_cmd(CMD_RELEASE, 16'h0003, 32'h0, 32'h0));
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // Fill the table: append to full, split in full, exact fit in full.
      for (int k = 0; k < DEPTH; k++)
         pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h0, 32'(k * 256), 32'(k % 3 + 8)));
      pending_cmds.push_back(make_cmd(CMD_APPEND, 16'h0, 32'h0, 32'd1));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 16'h0005, 32'h0, 32'd1));
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 16'h0005, 32'h0, 32'd10));
      pending_cmds.push_back(make_cmd(CMD_RELEASE, 16'h0005, 32'h0, 32'h0));
   endtask

   // Random phase: a fresh table of appends, then a mixed stream.
   task automatic load_random(int beats);
      int roll;
      pending_cmds.push_back(make_cmd(CMD_CLEAR, draw_owner(), 32'($urandom), 32'($urandom)));
      repeat ($urandom_range(3, 12))
         pending_cmds.push_back(make_cmd(CMD_APPEND, draw_owner(), 32'($urandom),
                                         32'($urandom_range(16, 256))));
      repeat (beats) begin
         roll = $urandom_range(0, 99);
         if (roll < 2)
            pending_cmds.push_back(make_cmd(CMD_CLEAR, draw_owner(), 32'($urandom),
                                            32'($urandom)));
         else if (roll < 14)
            pending_cmds.push_back(make_cmd(CMD_APPEND, draw_owner(), 32'($urandom),
                                            draw_size()));
         else if (roll < 60)
            pending_cmds.push_back(make_cmd(CMD_ALLOC, draw_owner(), 32'($urandom),
                                            draw_size()));
         else
            pending_cmds.push_back(make_cmd(CMD_RELEASE, draw_owner(), 32'($urandom),
                                            32'($urandom)));
      end
   endtask

   initial begin
      logic [1:0] policy_seq [6];
      policy_seq = '{POL_FIRST, POL_NEXT, POL_BEST, POL_WORST, POL_NEXT, POL_FIRST};
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      error_count   = 0;
      idle_cycles   = 0;
      gap_left      = 0;
      stim_done     = 1'b0;
      shadow_count  = 0;
      shadow_next   = 0;
      shadow_policy = POL_FIRST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Run the directed set once per policy, then random phases.
      for (int p = 0; p < 4; p++) begin
         write_policy(policy_seq[p]);
         load_directed();
         wait_drained();
      end
      for (int p = 0; p < 6; p++) begin
         write_policy(policy_seq[p]);
         load_random(140);
         wait_drained();
      end
      stim_done = 1'b1;

      if (error_count == 0)
         $display("variable_partition_allocator_tb: PASS");
      else
         $display("variable_partition_allocator_tb: FAIL");
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
design/vpa_pkg.sv
design/vpa_ram.sv
design/variable_partition_allocator.sv
design/vpa_checker.sv
bench/variable_partition_allocator_tb.sv
